/* rtl/assert_macros.svh */
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RPS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/rps_pkg.sv */
// Constants and codes shared by the relay power sequencer modules.
package rps_pkg;

  localparam int CHANNELS = 8;

  localparam logic [7:0] CHAN_MASK = 8'((1 << CHANNELS) - 1);

  localparam logic [15:0] STEP_MS      = 16'd100;
  localparam logic [15:0] MS_PER_S     = 16'd1000;
  localparam logic [15:0] LINK_SPAN_MS = 16'd8000;
  localparam logic [7:0]  MAX_DELAY_S  = 8'd65;

  localparam logic [1:0] STATUS_ALL_OFF = 2'd0;
  localparam logic [1:0] STATUS_ALL_ON  = 2'd1;
  localparam logic [1:0] STATUS_MIXED   = 2'd2;

  localparam logic [2:0] REG_ON_LO  = 3'd0;
  localparam logic [2:0] REG_ON_HI  = 3'd1;
  localparam logic [2:0] REG_OFF_LO = 3'd2;
  localparam logic [2:0] REG_OFF_HI = 3'd3;
  localparam logic [2:0] REG_LINKED = 3'd4;

  typedef struct packed {
    logic [31:0] on_lo;
    logic [31:0] on_hi;
    logic [31:0] off_lo;
    logic [31:0] off_hi;
    logic        linked;
  } cfg_t;

  function automatic logic [1:0] status_of(input logic [7:0] levels);
    logic [1:0] s;
    if (levels == CHAN_MASK) begin
      s = STATUS_ALL_ON;
    end else if (levels == 8'd0) begin
      s = STATUS_ALL_OFF;
    end else begin
      s = STATUS_MIXED;
    end
    return s;
  endfunction

endpackage

/* rtl/rps_switch_match.sv */
// Per-channel switching-time compare against the advanced counter.
module rps_switch_match
  import rps_pkg::*;
(
  input  cfg_t        cfg,
  input  logic        down,
  input  logic [15:0] count,
  output logic [7:0]  hits
);

  logic [63:0] on_bytes;
  logic [63:0] off_bytes;

  assign on_bytes  = {cfg.on_hi, cfg.on_lo};
  assign off_bytes = {cfg.off_hi, cfg.off_lo};

  always_comb begin
    logic [7:0]  d;
    logic [15:0] t;
    hits = 8'd0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      d = down ? on_bytes[ch*8 +: 8] : off_bytes[ch*8 +: 8];
      if (d > MAX_DELAY_S) begin
        d = MAX_DELAY_S;
      end
      if (cfg.linked) begin
        t = down ? 16'((ch + 1) * 1000) : 16'((8 - ch) * 1000);
      end else begin
        t = 16'({8'd0, d} * MS_PER_S);
      end
      hits[ch] = (count == t);
    end
  end

endmodule

/* rtl/relay_power_sequencer.sv */
// Top level of the eight-channel relay power sequencer.
// Each input item is one 100 ms tick carrying the key level; each produces exactly one
// result item with the channel levels, the status and the active counter. The tick is
// registered, evaluated combinationally against the counter and channel state, and the
// result is registered, so one item is taken every cycle unless the output stalls; the
// only loop is the state update through the on/off counters and channel levels. The
// result is valid once the held tick advances into the output registers. Configuration
// writes take effect at once and are meant to happen while the block is idle.
module relay_power_sequencer
  import rps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_key_down,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_channel_levels,
  output logic [1:0]  out_sequence_status,
  output logic [15:0] out_elapsed_ms,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic        in_valid_r;
  logic        in_key_r;
  logic [7:0]  levels_r, levels_nxt;
  logic [15:0] on_count_r, on_count_nxt;
  logic [15:0] off_count_r, off_count_nxt;
  logic        out_valid_r;
  logic [7:0]  out_levels_r;
  logic [1:0]  out_status_r;
  logic [15:0] out_elapsed_r;
  logic [1:0]  status;
  logic        advance;
  logic        run_on;
  logic        run_off;
  logic [15:0] count_adv;
  logic [7:0]  hits;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;
  assign status   = status_of(levels_r);
  assign run_on   = in_key_r && (status != STATUS_ALL_ON);
  assign run_off  = !in_key_r && (status != STATUS_ALL_OFF);
  assign count_adv = (in_key_r ? on_count_r : off_count_r) + STEP_MS;

  rps_switch_match u_match (
    .cfg   (cfg_r),
    .down  (in_key_r),
    .count (count_adv),
    .hits  (hits)
  );

  always_comb begin
    levels_nxt    = levels_r;
    on_count_nxt  = on_count_r;
    off_count_nxt = off_count_r;
    if (run_on) begin
      levels_nxt    = (levels_r | hits) & CHAN_MASK;
      on_count_nxt  = count_adv;
      off_count_nxt = cfg_r.linked ? LINK_SPAN_MS - count_adv : 16'd0;
    end else if (run_off) begin
      levels_nxt    = levels_r & ~hits & CHAN_MASK;
      off_count_nxt = count_adv;
      on_count_nxt  = cfg_r.linked ? LINK_SPAN_MS - count_adv : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ON_LO:  cfg_r.on_lo  <= cfg_wdata;
        REG_ON_HI:  cfg_r.on_hi  <= cfg_wdata;
        REG_OFF_LO: cfg_r.off_lo <= cfg_wdata;
        REG_OFF_HI: cfg_r.off_hi <= cfg_wdata;
        REG_LINKED: cfg_r.linked <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      levels_r    <= '0;
      on_count_r  <= '0;
      off_count_r <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        levels_r    <= levels_nxt;
        on_count_r  <= on_count_nxt;
        off_count_r <= off_count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_key_r <= in_key_down;
    end
    if (advance) begin
      out_levels_r  <= levels_nxt;
      out_status_r  <= status_of(levels_nxt);
      out_elapsed_r <= in_key_r ? on_count_nxt : off_count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_channel_levels  = out_levels_r;
  assign out_sequence_status = out_status_r;
  assign out_elapsed_ms      = out_elapsed_r;

`include "assert_macros.svh"

  `RPS_ASSERT(a_status_consistent, clk, rst_n, out_valid_r |-> ((out_status_r == STATUS_ALL_ON) == (out_levels_r == CHAN_MASK)), "status disagrees with channel levels")
  `RPS_ASSERT_NEVER(a_no_take_when_stalled, clk, rst_n, in_valid_r && !advance && in_ready, "input taken while held item is stalled")
  `RPS_ASSERT(a_on_monotone, clk, rst_n, advance && in_key_r |=> ((levels_r & $past(levels_r)) == $past(levels_r)), "channel turned off during key down")
  `RPS_ASSERT(a_off_cleared, clk, rst_n, advance && run_on && !cfg_r.linked |=> (off_count_r == 16'd0), "off counter not cleared in normal mode")

endmodule
